// ===== rtl/core/stp_pkg.sv =====
// Shared types and constants for the string-to-integer parser.
// No dependencies; used by the front, back and top-level modules.
package stp_pkg;

    localparam int unsigned ACC_W     = 64;
    localparam int unsigned RADIX_W   = 5;
    localparam int unsigned CHAR_W    = 8;
    localparam int unsigned CNT_OUT_W = 12;
    localparam int unsigned DIGIT_W   = 5;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
    localparam logic [RADIX_W-1:0] RADIX_AUTO  = 5'd0;
    localparam logic [RADIX_W-1:0] RADIX_OCT   = 5'd8;
    localparam logic [RADIX_W-1:0] RADIX_DEC   = 5'd10;
    localparam logic [RADIX_W-1:0] RADIX_HEX   = 5'd16;
    localparam logic [DIGIT_W-1:0] DIGIT_NONE  = 5'd16;

    // Classified character as it travels from front to back
    typedef struct packed {
        logic               is_space;
        logic               is_minus;
        logic               is_plus;
        logic               is_zero;
        logic               is_x;
        logic [DIGIT_W-1:0] digit;
        logic               last;
    } char_class_t;

endpackage

// ===== rtl/core/stp_front.sv =====
// Front end: accepts characters, classifies them and queues the classes.
// Depends on stp_pkg.
module stp_front (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [stp_pkg::CHAR_W-1:0] s_char_code,
    input  logic                      s_last_char,
    output logic                      head_valid,
    output stp_pkg::char_class_t      head,
    input  logic                      head_pop
);

    localparam int unsigned DEPTH = 2;

    stp_pkg::char_class_t cls;
    stp_pkg::char_class_t queue_mem [DEPTH];
    logic                 wr_ptr_reg, wr_ptr_next;
    logic                 rd_ptr_reg, rd_ptr_next;
    logic [1:0]           count_reg, count_next;
    logic                 push;

    always_comb begin
        cls          = '0;
        cls.is_space = (s_char_code == 8'h20) || (s_char_code inside {[8'h09:8'h0D]});
        cls.is_minus = (s_char_code == 8'h2D);
        cls.is_plus  = (s_char_code == 8'h2B);
        cls.is_zero  = (s_char_code == 8'h30);
        cls.is_x     = (s_char_code == 8'h78) || (s_char_code == 8'h58);
        cls.last     = s_last_char;
        if (s_char_code inside {[8'h30:8'h39]}) begin
            cls.digit = 5'(s_char_code - 8'h30);
        end else if (s_char_code inside {[8'h61:8'h66]}) begin
            cls.digit = 5'(s_char_code - 8'h57);
        end else if (s_char_code inside {[8'h41:8'h46]}) begin
            cls.digit = 5'(s_char_code - 8'h37);
        end else begin
            cls.digit = stp_pkg::DIGIT_NONE;
        end
    end

    assign s_ready    = (count_reg != 2'(DEPTH));
    assign push       = s_valid && s_ready;
    assign head_valid = (count_reg != 2'd0);
    assign head       = queue_mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = head_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(head_pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_mem[wr_ptr_reg] <= cls;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/core/stp_back.sv =====
// Back end: parse state machine, signed accumulator, consumed count and
// the result output register. Depends on stp_pkg.
module stp_back #(
    parameter int unsigned MAX_COUNT = 4095,
    parameter int unsigned CNT_W     = 12
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [stp_pkg::RADIX_W-1:0]   cfg_wdata,
    input  logic                          head_valid,
    input  stp_pkg::char_class_t          head,
    output logic                          head_pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [stp_pkg::ACC_W-1:0]    m_parsed_value,
    output logic [stp_pkg::CNT_OUT_W-1:0] m_chars_consumed
);

    localparam logic [2:0] PH_SPACE  = 3'd0;
    localparam logic [2:0] PH_SIGNED = 3'd1;
    localparam logic [2:0] PH_ZERO0  = 3'd2;
    localparam logic [2:0] PH_ZERO16 = 3'd3;
    localparam logic [2:0] PH_DIGITS = 3'd4;
    localparam logic [2:0] PH_DONE   = 3'd5;

    logic [stp_pkg::RADIX_W-1:0] radix_reg;
    logic [2:0]                  phase_reg, phase_next;
    logic                        neg_reg, neg_next;
    logic [stp_pkg::RADIX_W-1:0] aradix_reg, aradix_next;
    logic [stp_pkg::ACC_W-1:0]   acc_reg, acc_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next, cnt_inc;
    logic                        m_valid_reg;
    logic [stp_pkg::ACC_W-1:0]   m_value_reg;
    logic [stp_pkg::CNT_OUT_W-1:0] m_count_reg;
    logic [16:0]                 cnt_wide;

    logic                        first, do_digit, inc;
    logic [stp_pkg::RADIX_W-1:0] dig_radix;
    logic [stp_pkg::ACC_W-1:0]   prod;
    logic                        out_free;

    assign out_free = !m_valid_reg || m_ready;
    // A last character needs the output slot; others go straight through
    assign head_pop = head_valid && (!head.last || out_free);

    assign cnt_inc = (cnt_reg < CNT_W'(MAX_COUNT)) ? cnt_reg + CNT_W'(1) : cnt_reg;
    assign prod    = 64'(acc_reg * 64'(dig_radix));

    always_comb begin
        phase_next  = phase_reg;
        neg_next    = neg_reg;
        aradix_next = aradix_reg;
        acc_next    = acc_reg;
        first       = 1'b0;
        do_digit    = 1'b0;
        inc         = 1'b0;
        dig_radix   = aradix_reg;

        case (phase_reg)
            PH_SPACE: begin
                if (head.is_space) begin
                    inc = 1'b1;
                end else if (head.is_minus) begin
                    neg_next   = 1'b1;
                    inc        = 1'b1;
                    phase_next = PH_SIGNED;
                end else if (head.is_plus) begin
                    inc        = 1'b1;
                    phase_next = PH_SIGNED;
                end else begin
                    first = 1'b1;
                end
            end
            PH_SIGNED: begin
                first = 1'b1;
            end
            PH_ZERO0: begin
                if (head.is_x) begin
                    aradix_next = stp_pkg::RADIX_HEX;
                    inc         = 1'b1;
                    phase_next  = PH_DIGITS;
                end else begin
                    aradix_next = stp_pkg::RADIX_OCT;
                    dig_radix   = stp_pkg::RADIX_OCT;
                    do_digit    = 1'b1;
                end
            end
            PH_ZERO16: begin
                if (head.is_x) begin
                    inc        = 1'b1;
                    phase_next = PH_DIGITS;
                end else begin
                    do_digit = 1'b1;
                end
            end
            PH_DIGITS: begin
                do_digit = 1'b1;
            end
            default: begin
                phase_next = PH_DONE;
            end
        endcase

        // First character after whitespace and sign latches the base
        if (first) begin
            if (radix_reg == stp_pkg::RADIX_AUTO) begin
                if (head.is_zero) begin
                    inc        = 1'b1;
                    phase_next = PH_ZERO0;
                end else begin
                    aradix_next = stp_pkg::RADIX_DEC;
                    dig_radix   = stp_pkg::RADIX_DEC;
                    do_digit    = 1'b1;
                end
            end else begin
                aradix_next = radix_reg;
                if (radix_reg == stp_pkg::RADIX_HEX && head.is_zero) begin
                    inc        = 1'b1;
                    phase_next = PH_ZERO16;
                end else begin
                    dig_radix = radix_reg;
                    do_digit  = 1'b1;
                end
            end
        end

        // Accumulate the signed value directly: subtract digits when negative
        if (do_digit) begin
            if (head.digit[4] || head.digit >= dig_radix) begin
                phase_next = PH_DONE;
            end else begin
                acc_next   = neg_reg ? prod - 64'(head.digit) : prod + 64'(head.digit);
                inc        = 1'b1;
                phase_next = PH_DIGITS;
            end
        end

        cnt_next = inc ? cnt_inc : cnt_reg;
    end

    assign cnt_wide = 17'(cnt_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg <= stp_pkg::RADIX_RESET;
        end else if (cfg_we) begin
            radix_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_SPACE;
            neg_reg    <= 1'b0;
            aradix_reg <= '0;
            acc_reg    <= '0;
            cnt_reg    <= '0;
        end else if (head_pop) begin
            if (head.last) begin
                phase_reg  <= PH_SPACE;
                neg_reg    <= 1'b0;
                aradix_reg <= '0;
                acc_reg    <= '0;
                cnt_reg    <= '0;
            end else begin
                phase_reg  <= phase_next;
                neg_reg    <= neg_next;
                aradix_reg <= aradix_next;
                acc_reg    <= acc_next;
                cnt_reg    <= cnt_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (head_pop && head.last) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (head_pop && head.last) begin
            m_value_reg <= acc_next;
            m_count_reg <= cnt_wide[stp_pkg::CNT_OUT_W-1:0];
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_parsed_value   = m_value_reg;
    assign m_chars_consumed = m_count_reg;

endmodule

// ===== rtl/core/string_to_integer_parser_top.sv =====
// String-to-integer parser, one character per transfer.
// A last character is queued in front; its result is then registered in the back end.
// Throughput: one character per cycle, one multiply-add by the base in the back end each,
// unless a stalled result holds a last character back in the queue.
// Reset (aresetn low, synchronous): queue empty, parse state cleared, radix 10.
module string_to_integer_parser_top #(
    parameter int unsigned MAX_COUNT = 4095
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [stp_pkg::RADIX_W-1:0]   cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [stp_pkg::CHAR_W-1:0]    s_char_code,
    input  logic                          s_last_char,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [stp_pkg::ACC_W-1:0] m_parsed_value,
    output logic [stp_pkg::CNT_OUT_W-1:0] m_chars_consumed
);

    localparam int unsigned CNT_W = $clog2(MAX_COUNT + 1);

    logic                 head_valid;
    logic                 head_pop;
    stp_pkg::char_class_t head;

    stp_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_char_code (s_char_code),
        .s_last_char (s_last_char),
        .head_valid  (head_valid),
        .head        (head),
        .head_pop    (head_pop)
    );

    stp_back #(
        .MAX_COUNT (MAX_COUNT),
        .CNT_W     (CNT_W)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .head_valid       (head_valid),
        .head             (head),
        .head_pop         (head_pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_parsed_value   (m_parsed_value),
        .m_chars_consumed (m_chars_consumed)
    );

endmodule

// ===== rtl/core/stp_checker.sv =====
// Port-level checks for the string-to-integer parser, bound to the top level.
// Depends on stp_pkg and string_to_integer_parser_top.
module stp_checker #(
    parameter int unsigned MAX_COUNT = 4095
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic signed [stp_pkg::ACC_W-1:0] m_parsed_value,
    input logic [stp_pkg::CNT_OUT_W-1:0] m_chars_consumed
);

    // Reset empties the queue and drops any pending result
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid && s_ready))
        else $error("reset did not clear queue and output");

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_parsed_value)
                                   && $stable(m_chars_consumed)))
        else $error("stalled result changed");

    // A nonzero value needs at least one consumed character
    a_zero_count_zero_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (MAX_COUNT <= 4095) && (m_chars_consumed == '0))
            |-> (m_parsed_value == '0))
        else $error("value without consumed characters");

    // Count never exceeds the saturation limit
    a_count_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (MAX_COUNT <= 4095)) |-> (32'(m_chars_consumed) <= MAX_COUNT))
        else $error("consumed count above limit");

endmodule

bind string_to_integer_parser_top stp_checker #(
    .MAX_COUNT (MAX_COUNT)
) u_stp_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_parsed_value   (m_parsed_value),
    .m_chars_consumed (m_chars_consumed)
);

// ===== tb/sv/string_to_integer_parser_top_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for string_to_integer_parser_top: random-stall driver and
// monitor, in-bench strtol-style predictor, radix sweep. Depends on stp_pkg and the RTL.
module string_to_integer_parser_top_test;

    localparam int unsigned CHAR_W    = stp_pkg::CHAR_W;
    localparam int unsigned ACC_W     = stp_pkg::ACC_W;
    localparam int unsigned CNT_OUT_W = stp_pkg::CNT_OUT_W;
    localparam int unsigned RADIX_W   = stp_pkg::RADIX_W;
    localparam int unsigned DIGIT_W   = stp_pkg::DIGIT_W;

    localparam int unsigned MAX_COUNT   = 4095;
    localparam int unsigned IDLE_PCT    = 19;
    localparam int unsigned DRAIN_TICKS = 6;

    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0d;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
    localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UF    = 8'h46;
    localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
    localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h66;
    localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;

    typedef enum logic [2:0] {
        SKIP_SPACE, AFTER_SIGN, ZERO_AUTO, ZERO_HEX, IN_DIGITS, STOPPED
    } scan_phase_t;

    typedef struct {
        logic [CHAR_W-1:0] code;
        logic              last;
    } text_char_t;

    typedef struct {
        logic [ACC_W-1:0]     value;
        logic [CNT_OUT_W-1:0] count;
    } parse_result_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [RADIX_W-1:0]     cfg_wdata = stp_pkg::RADIX_RESET;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [CHAR_W-1:0]      s_char_code = '0;
    logic                   s_last_char = 1'b0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic signed [ACC_W-1:0] m_parsed_value;
    logic [CNT_OUT_W-1:0]   m_chars_consumed;

    text_char_t    char_stream[$];
    parse_result_t expected_numbers[$];

    // predictor state
    logic [RADIX_W-1:0] radix_setting = stp_pkg::RADIX_RESET;
    scan_phase_t        phase;
    logic               negative;
    logic [RADIX_W-1:0] base;
    logic [ACC_W-1:0]   acc;
    int unsigned        consumed;

    bit          steady = 1'b0;
    int unsigned errors = 0;
    int unsigned chars_sent = 0;
    int unsigned numbers_checked = 0;
    int unsigned radix_writes = 0;

    string_to_integer_parser_top #(.MAX_COUNT(MAX_COUNT)) uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_char_code      (s_char_code),
        .s_last_char      (s_last_char),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_parsed_value   (m_parsed_value),
        .m_chars_consumed (m_chars_consumed)
    );

    always #5 aclk = ~aclk;

    // ---------------- predictor ----------------

    task automatic clear_scan();
        phase    = SKIP_SPACE;
        negative = 1'b0;
        base     = '0;
        acc      = '0;
        consumed = 0;
    endtask

    task automatic count_char();
        if (consumed < MAX_COUNT) begin
            consumed++;
        end
    endtask

    function automatic logic [DIGIT_W-1:0] digit_value(logic [CHAR_W-1:0] c);
        if (c >= CH_0 && c <= CH_9) return DIGIT_W'(c - CH_0);
        if (c >= CH_LA && c <= CH_LF) return DIGIT_W'(c - CH_LA + 10);
        if (c >= CH_UA && c <= CH_UF) return DIGIT_W'(c - CH_UA + 10);
        return stp_pkg::DIGIT_NONE;
    endfunction

    task automatic accumulate(logic [CHAR_W-1:0] c);
        logic [DIGIT_W-1:0] d;
        d = digit_value(c);
        if (d >= stp_pkg::DIGIT_NONE || d >= base) begin
            phase = STOPPED;
        end else begin
            acc = acc * ACC_W'(base) + ACC_W'(d);
            count_char();
            phase = IN_DIGITS;
        end
    endtask

    // latch the base on the first character past whitespace and sign
    task automatic open_number(logic [CHAR_W-1:0] c);
        if (radix_setting == stp_pkg::RADIX_AUTO) begin
            if (c == CH_0) begin
                count_char();
                phase = ZERO_AUTO;
            end else begin
                base = stp_pkg::RADIX_DEC;
                accumulate(c);
            end
        end else begin
            base = radix_setting;
            if (radix_setting == stp_pkg::RADIX_HEX && c == CH_0) begin
                count_char();
                phase = ZERO_HEX;
            end else begin
                accumulate(c);
            end
        end
    endtask

    task automatic scan_char(logic [CHAR_W-1:0] c, logic last);
        case (phase)
            SKIP_SPACE: begin
                if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
                    count_char();
                end else if (c == CH_MINUS) begin
                    negative = 1'b1;
                    count_char();
                    phase = AFTER_SIGN;
                end else if (c == CH_PLUS) begin
                    count_char();
                    phase = AFTER_SIGN;
                end else begin
                    open_number(c);
                end
            end
            AFTER_SIGN: open_number(c);
            ZERO_AUTO: begin
                if (c == CH_LX || c == CH_UX) begin
                    base = stp_pkg::RADIX_HEX;
                    count_char();
                    phase = IN_DIGITS;
                end else begin
                    base = stp_pkg::RADIX_OCT;
                    accumulate(c);
                end
            end
            ZERO_HEX: begin
                if (c == CH_LX || c == CH_UX) begin
                    count_char();
                    phase = IN_DIGITS;
                end else begin
                    accumulate(c);
                end
            end
            IN_DIGITS: accumulate(c);
            default: phase = STOPPED;
        endcase
        if (last) begin
            expected_numbers.push_back('{negative ? -acc : acc, CNT_OUT_W'(consumed)});
            clear_scan();
        end
    endtask

    // ---------------- driver and monitor ----------------

    always @(posedge aclk) begin : drive_chars
        text_char_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                scan_char(s_char_code, s_last_char);
                chars_sent++;
            end
            if (!s_valid || s_ready) begin
                if (char_stream.size() != 0
                    && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    nxt = char_stream.pop_front();
                    s_valid     <= 1'b1;
                    s_char_code <= nxt.code;
                    s_last_char <= nxt.last;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : check_numbers
        parse_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_numbers.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result: expected none, got value %0d count %0d",
                             $time, m_parsed_value, m_chars_consumed);
                end else begin
                    want = expected_numbers.pop_front();
                    numbers_checked++;
                    if (m_parsed_value !== want.value) begin
                        errors++;
                        $display("%0t: parsed_value mismatch: expected %0d, got %0d",
                                 $time, $signed(want.value), m_parsed_value);
                    end
                    if (m_chars_consumed !== want.count) begin
                        errors++;
                        $display("%0t: chars_consumed mismatch: expected %0d, got %0d",
                                 $time, want.count, m_chars_consumed);
                    end
                end
            end
            m_ready <= steady || $urandom_range(0, 99) >= IDLE_PCT;
        end
    end

    // ---------------- stimulus ----------------

    task automatic push_char(logic [CHAR_W-1:0] c, bit close);
        char_stream.push_back('{c, close});
    endtask

    task automatic push_text(string s, bit close);
        for (int i = 0; i < s.len(); i++) begin
            push_char(s[i], close && i == s.len() - 1);
        end
    endtask

    // hold until every transfer is done and every result is back
    task automatic settle();
        while (char_stream.size() != 0 || s_valid || expected_numbers.size() != 0) begin
            @(negedge aclk);
        end
        repeat (DRAIN_TICKS) @(negedge aclk);
    endtask

    task automatic set_radix(logic [RADIX_W-1:0] r);
        settle();
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= r;
        radix_setting = r;
        radix_writes++;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    function automatic logic [CHAR_W-1:0] digit_char(int unsigned v);
        if (v < 10) return CH_0 + CHAR_W'(v);
        return ($urandom_range(0, 1) ? CH_LA : CH_UA) + CHAR_W'(v - 10);
    endfunction

    // mostly well-formed numbers with random content, some noise and broken ones
    task automatic push_random_number(output int unsigned len);
        logic [CHAR_W-1:0] text[$];
        int unsigned       kind;
        int unsigned       gen_base;
        int unsigned       ndig;
        int unsigned       pick;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            repeat ($urandom_range(1, 8)) text.push_back(CHAR_W'($urandom_range(0, 255)));
        end else begin
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 3)) begin
                    pick = $urandom_range(9, 14);
                    text.push_back(pick == 14 ? CH_SPACE : CHAR_W'(pick));
                end
            end
            pick = $urandom_range(0, 3);
            if (pick == 0) text.push_back(CH_MINUS);
            else if (pick == 1) text.push_back(CH_PLUS);
            if (kind == 1) text.push_back(CHAR_W'($urandom_range(0, 255)));
            gen_base = radix_setting > stp_pkg::RADIX_HEX ? 16 : radix_setting;
            if (radix_setting == stp_pkg::RADIX_AUTO || radix_setting == stp_pkg::RADIX_HEX) begin
                pick = $urandom_range(0, 3);
                if (pick <= 1) begin
                    text.push_back(CH_0);
                    text.push_back(pick == 0 ? CH_LX : CH_UX);
                    gen_base = 16;
                end else if (pick == 2 && radix_setting == stp_pkg::RADIX_AUTO) begin
                    text.push_back(CH_0);
                    gen_base = 8;
                end else if (radix_setting == stp_pkg::RADIX_AUTO) begin
                    gen_base = 10;
                end
            end
            ndig = ($urandom_range(0, 7) == 0) ? $urandom_range(18, 26) : $urandom_range(0, 12);
            repeat (ndig) begin
                if ($urandom_range(0, 19) == 0) text.push_back(digit_char($urandom_range(0, 15)));
                else text.push_back(digit_char($urandom_range(0, gen_base - 1)));
            end
            repeat ($urandom_range(0, 2)) text.push_back(CHAR_W'($urandom_range(0, 255)));
            if (text.size() == 0) text.push_back(digit_char($urandom_range(0, 15)));
        end
        len = text.size();
        foreach (text[i]) push_char(text[i], i == text.size() - 1);
    endtask

    initial begin
        logic [RADIX_W-1:0] sweep[10];
        int unsigned        phase_chars;
        int unsigned        len;

        clear_scan();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset radix (decimal): signs, whitespace, wrap, stop characters
        push_text(" \t-123x", 1);
        push_char(8'h0b, 0);
        push_char(8'h0c, 0);
        push_char(8'h0a, 0);
        push_text("+9223372036854775807", 1);
        push_text("-9223372036854775808", 1);
        push_text("99999999999999999999", 1);
        push_text("- 5", 1);
        push_text("12", 0);
        push_char(8'h00, 0);
        push_text("34", 1);
        push_char(8'hff, 1);
        push_char(8'h00, 1);
        // short whitespace run ahead of a digit
        repeat (4) push_char(CH_SPACE, 0);
        push_text("7", 1);

        set_radix(stp_pkg::RADIX_AUTO);
        push_text("0x1F", 1);
        push_text("0X", 1);
        push_text("017", 1);
        push_text("0", 1);
        push_text("089", 1);
        push_text("42", 1);
        push_text("0xg", 1);
        push_text("-0x8000000000000000", 1);

        set_radix(stp_pkg::RADIX_HEX);
        push_text("0xff", 1);
        push_text("0x", 1);
        push_text("-0XDEADbeef", 1);
        push_text("ab", 1);
        push_text("FFFFFFFFFFFFFFFFF", 1);

        set_radix(5'd1);
        push_text("000", 1);
        push_text("01", 1);

        set_radix(5'd31);
        push_text("fF9", 1);
        push_text("g", 1);

        sweep = '{stp_pkg::RADIX_DEC, stp_pkg::RADIX_AUTO, stp_pkg::RADIX_HEX,
                  stp_pkg::RADIX_OCT, 5'd2, 5'd1, 5'd31,
                  RADIX_W'($urandom_range(17, 30)), RADIX_W'($urandom_range(0, 31)),
                  stp_pkg::RADIX_AUTO};
        foreach (sweep[p]) begin
            set_radix(sweep[p]);
            steady = (p == 2);
            phase_chars = 0;
            while (phase_chars < 75) begin
                push_random_number(len);
                phase_chars += len;
            end
        end
        settle();
        steady = 1'b0;

        $display("Checked %0d parsed numbers from %0d characters across %0d radix writes,",
                 numbers_checked, chars_sent, radix_writes);
        $display("including auto-detect, radix 1, 16, 31, stop characters and 64-bit wrap.");
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timeout with %0d results outstanding", expected_numbers.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule
